/* sv/fcrle_pkg.sv */
`default_nettype none

package fcrle_pkg;

  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] ONE       = 32'h3F80_0000;
  localparam logic [31:0] MINUS_ONE = 32'hBF80_0000;
  localparam logic [31:0] TWO       = 32'h4000_0000;
  localparam logic [31:0] NEG_INF   = 32'hFF80_0000;
  localparam logic [31:0] LN_C3     = 32'h3DD8_ADAC;  // 0.1058
  localparam logic [31:0] LN_C2     = 32'hBF37_7319;  // -0.7166
  localparam logic [31:0] LN_C1     = 32'h4005_930C;  // 2.0871
  localparam logic [31:0] LN_C0     = 32'hBFBC_D6A1;  // -1.4753
  localparam logic [31:0] LN2       = 32'h3F31_5FFE;  // 0.692871
  localparam logic [31:0] THIRD     = 32'h3EAA_AA9F;  // 0.333333
  localparam logic [31:0] EX_C2     = 32'h3F56_594B;  // 0.8373
  localparam logic [31:0] EX_C1     = 32'h3F5D_0000;  // 0.86328125
  localparam logic [31:0] LOG2E     = 32'h3FB8_AA3B;  // 1.442695

  typedef enum logic [2:0] {
    OPK_MUL, OPK_ADD, OPK_LNPREP, OPK_LNFIX, OPK_EXPPREP, OPK_RECPREP, OPK_REBIAS
  } opk_t;

  typedef enum logic [2:0] {SRC_T, SRC_V, SRC_U, SRC_K, SRC_SGN} src_t;

  typedef enum logic {DST_T, DST_U} dst_t;

  typedef struct packed {
    opk_t        kind;
    src_t        a;
    src_t        b;
    dst_t        d;
    logic [31:0] k;
    logic        sq;
    logic [2:0]  sqi;
  } op_t;

  // Working set that travels with each request down the pipeline.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] t;
    logic [31:0] v;
    logic [31:0] u;
    logic        neg;
    logic        zf;
    logic        yneg;
    logic [3:0]  n;
  } ctx_t;

  // Unrounded result: value is m * 2^(eb - 127), or a finished word.
  typedef struct packed {
    logic               spec;
    logic [31:0]        sbits;
    logic               s;
    logic signed [10:0] eb;
    logic [63:0]        m;
  } raw_t;

  localparam int NOPS = 36;

  localparam op_t OP_TAB [NOPS] = '{
    '{OPK_LNPREP,  SRC_T, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_K, DST_T, LN_C3, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, LN_C2, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, LN_C1, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, LN_C0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_U, SRC_K, DST_U, LN2,   1'b0, 3'd0},
    '{OPK_ADD,     SRC_U, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_LNFIX,   SRC_T, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_T, SRC_K, DST_T, THIRD, 1'b0, 3'd0},
    '{OPK_EXPPREP, SRC_T, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_K, DST_T, EX_C2, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, EX_C1, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, ONE,   1'b0, 3'd0},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd0},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd1},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd2},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd3},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd4},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd5},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd6},
    '{OPK_MUL,     SRC_T, SRC_T, DST_T, 32'h0, 1'b1, 3'd7},
    '{OPK_RECPREP, SRC_T, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_K, DST_T, LOG2E, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, TWO,   1'b0, 3'd0},
    '{OPK_MUL,     SRC_T, SRC_K, DST_U, LOG2E, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_U, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, TWO,   1'b0, 3'd0},
    '{OPK_MUL,     SRC_U, SRC_T, DST_U, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_V, SRC_U, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_ADD,     SRC_T, SRC_K, DST_T, TWO,   1'b0, 3'd0},
    '{OPK_MUL,     SRC_U, SRC_T, DST_U, 32'h0, 1'b0, 3'd0},
    '{OPK_REBIAS,  SRC_T, SRC_T, DST_T, 32'h0, 1'b0, 3'd0},
    '{OPK_MUL,     SRC_T, SRC_SGN, DST_T, 32'h0, 1'b0, 3'd0}
  };

  function automatic logic is_nan32(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] op_sel(src_t s, ctx_t c, logic [31:0] k);
    logic [31:0] r;
    unique case (s)
      SRC_T:   r = c.t;
      SRC_V:   r = c.v;
      SRC_U:   r = c.u;
      SRC_K:   r = k;
      SRC_SGN: r = c.neg ? MINUS_ONE : ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic raw_t fmul_raw(logic [31:0] a, logic [31:0] b);
    raw_t        r;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] pr;
    r  = '0;
    ea = a[30:23];
    eb = b[30:23];
    r.s = a[31] ^ b[31];
    pr = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    if (is_nan32(a) || is_nan32(b)) begin
      r.spec  = 1'b1;
      r.sbits = QNAN;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      r.spec  = 1'b1;
      r.sbits = (ea == 8'd0 || eb == 8'd0) ? QNAN : {r.s, 8'hFF, 23'd0};
    end else if (ea == 8'd0 || eb == 8'd0) begin
      r.spec  = 1'b1;
      r.sbits = {r.s, 31'd0};
    end else begin
      r.m  = {16'd0, pr};
      r.eb = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd173;
    end
    return r;
  endfunction

  function automatic raw_t fadd_raw(logic [31:0] a, logic [31:0] b);
    raw_t        r;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  d;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] sum;
    r  = '0;
    ea = a[30:23];
    eb = b[30:23];
    if (b[30:0] > a[30:0]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    ma  = {2'b01, hi[22:0], 39'd0};
    mb  = {2'b01, lo[22:0], 39'd0};
    d   = hi[30:23] - lo[30:23];
    mb  = (d >= 8'd40) ? 64'd1 : (mb >> d);
    sum = (a[31] ^ b[31]) ? (ma - mb) : (ma + mb);
    r.spec = 1'b1;
    if (is_nan32(a) || is_nan32(b)) begin
      r.sbits = QNAN;
    end else if (ea == 8'hFF && eb == 8'hFF) begin
      r.sbits = (a[31] ^ b[31]) ? QNAN : a;
    end else if (ea == 8'hFF) begin
      r.sbits = a;
    end else if (eb == 8'hFF) begin
      r.sbits = b;
    end else if (ea == 8'd0 && eb == 8'd0) begin
      r.sbits = {a[31] & b[31], 31'd0};
    end else if (ea == 8'd0) begin
      r.sbits = b;
    end else if (eb == 8'd0) begin
      r.sbits = a;
    end else if (sum == 64'd0) begin
      r.sbits = 32'd0;
    end else begin
      r.spec = 1'b0;
      r.s    = hi[31];
      r.eb   = $signed({3'd0, hi[30:23]}) - 11'sd62;
      r.m    = sum;
    end
    return r;
  endfunction

  function automatic logic [5:0] lead_pos(logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = i[5:0];
    end
    return p;
  endfunction

  function automatic logic [31:0] round_fin(raw_t r, logic [5:0] p);
    logic [5:0]         sh;
    logic [63:0]        q;
    logic [63:0]        rm;
    logic [63:0]        h;
    logic               rnd;
    logic [24:0]        q1;
    logic signed [11:0] e;
    logic [31:0]        res;
    sh  = p - 6'd23;
    q   = r.m >> sh;
    rm  = r.m & ((64'd1 << sh) - 64'd1);
    h   = 64'd1 << (sh - 6'd1);
    rnd = (rm > h) || ((rm == h) && q[0]);
    q1  = q[24:0] + {24'd0, rnd};
    e   = {r.eb[10], r.eb} + $signed({6'd0, p});
    if (q1[24]) begin
      q1 = q1 >> 1;
      e  = e + 12'sd1;
    end
    if (r.spec) begin
      res = r.sbits;
    end else if (e >= 12'sd255) begin
      res = {r.s, 8'hFF, 23'd0};
    end else if (e <= 12'sd0) begin
      res = {r.s, 31'd0};
    end else begin
      res = {r.s, e[7:0], q1[22:0]};
    end
    return res;
  endfunction

  // Float encoding of (f - 127) for an exponent field f.
  function automatic logic [31:0] exp_int_bits(logic [7:0] f);
    logic       s;
    logic [7:0] mag;
    logic [2:0] pp;
    logic [22:0] w;
    s   = (f < 8'd127);
    mag = s ? (8'd127 - f) : (f - 8'd127);
    pp  = '0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) pp = i[2:0];
    end
    w = 23'({15'd0, mag} << (5'd23 - {2'd0, pp}));
    return (mag == 8'd0) ? 32'd0 : {s, 8'd127 + {5'd0, pp}, w};
  endfunction

  function automatic ctx_t step_special(opk_t kind, ctx_t ci);
    ctx_t              c;
    logic [31:0]       xf;
    logic [7:0]        f;
    logic signed [9:0] ne;
    logic [31:0]       r;
    c  = ci;
    xf = ci.x;
    f  = ci.t[30:23];
    ne = $signed({2'd0, ci.u[30:23]}) - $signed({2'd0, ci.x[30:23]}) + 10'sd126;
    r  = (ne < 10'sd0) ? 32'd0 : {ci.u[31], ne[7:0], ci.u[22:0]};
    unique case (kind)
      OPK_LNPREP: begin
        if (xf[30:23] == 8'd0) xf = {xf[31], 31'd0};
        c.x   = xf;
        c.neg = xf[31] && (xf[30:0] != 31'd0);
        c.zf  = (xf[30:0] == 31'd0);
        c.v   = {1'b0, 8'd127, xf[22:0]};
        c.u   = exp_int_bits(xf[30:23]);
      end
      OPK_LNFIX: begin
        if (ci.zf) c.t = NEG_INF;
      end
      OPK_EXPPREP: begin
        c.yneg = ci.t[31] && (ci.t[30:0] != 31'd0);
        if (f >= 8'd127) begin
          c.v = {1'b0, 8'd126, ci.t[22:0]};
          c.n = (f >= 8'd134) ? 4'd8 : 4'(f - 8'd126);
        end else begin
          c.v = {1'b0, ci.t[30:0]};
          c.n = 4'd0;
        end
      end
      OPK_RECPREP: begin
        c.x = ci.t;
        c.v = {1'b1, 8'd126, ci.t[22:0]};
      end
      OPK_REBIAS: begin
        c.t = ci.yneg ? r : ci.x;
      end
      default: begin
        c = ci;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/fp32_cube_root_log_exp_top.sv */
// Approximate fp32 cube root, sign(x) * exp(ln|x| / 3).
// Input channel: in_valid / in_ready with in_operand_bits, one raw IEEE word
// per request. Result channel: out_valid / out_ready with out_result_bits.
// Every request gives exactly one result, in order.
// The evaluation is a fixed chain of 31 fp32 multiplies and adds plus five
// bit-manipulation steps. Each multiply or add takes three register stages
// (operand align or multiply, leading-one search, round and pack); each
// bit-manipulation step takes one, for 98 register stages in all. The
// request enters the first stage at its accepting edge, out_valid rises when
// it is in the last, and one request can enter per cycle while not stalled.
// The whole pipeline advances as one: when the last stage holds a result that
// the receiver does not take, every stage holds, in_ready drops, and nothing
// is lost or repeated. Bubbles move on while the last stage is empty.
// Reset (synchronous, active low) clears all stage valid bits; data registers
// are not reset.
`default_nettype none

module fp32_cube_root_log_exp_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_operand_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result_bits
);

  localparam int NOPS = fcrle_pkg::NOPS;

  fcrle_pkg::ctx_t ctx_q [NOPS+1];
  logic            vld_q [NOPS+1];
  logic            en;

  assign en       = out_ready || !vld_q[NOPS];
  assign in_ready = en;

  always_comb begin
    ctx_q[0]   = '0;
    ctx_q[0].x = in_operand_bits;
    vld_q[0]   = in_valid;
  end

  for (genvar gi = 0; gi < NOPS; gi++) begin : g_op
    localparam fcrle_pkg::op_t OP = fcrle_pkg::OP_TAB[gi];
    if (OP.kind == fcrle_pkg::OPK_MUL || OP.kind == fcrle_pkg::OPK_ADD) begin : g_arith
      fcrle_pkg::ctx_t c1_r, c2_r;
      fcrle_pkg::ctx_t c3_nxt;
      fcrle_pkg::raw_t r1_r, r2_r;
      fcrle_pkg::raw_t raw_nxt;
      logic [5:0]      p2_r;
      logic            v1_r, v2_r;
      logic [31:0]     opa;
      logic [31:0]     opb;
      logic [31:0]     res;

      always_comb begin
        opa = fcrle_pkg::op_sel(OP.a, ctx_q[gi], OP.k);
        opb = fcrle_pkg::op_sel(OP.b, ctx_q[gi], OP.k);
        if (OP.kind == fcrle_pkg::OPK_MUL) begin
          raw_nxt = fcrle_pkg::fmul_raw(opa, opb);
        end else begin
          raw_nxt = fcrle_pkg::fadd_raw(opa, opb);
        end
        // A squaring beyond this request's count passes the value through.
        if (OP.sq && !(ctx_q[gi].n > {1'b0, OP.sqi})) begin
          raw_nxt       = '0;
          raw_nxt.spec  = 1'b1;
          raw_nxt.sbits = ctx_q[gi].t;
        end
        res    = fcrle_pkg::round_fin(r2_r, p2_r);
        c3_nxt = c2_r;
        if (OP.d == fcrle_pkg::DST_T) begin
          c3_nxt.t = res;
        end else begin
          c3_nxt.u = res;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r          <= 1'b0;
          v2_r          <= 1'b0;
          vld_q[gi+1]   <= 1'b0;
        end else if (en) begin
          v1_r          <= vld_q[gi];
          v2_r          <= v1_r;
          vld_q[gi+1]   <= v2_r;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c1_r <= ctx_q[gi];
          r1_r <= raw_nxt;
          c2_r <= c1_r;
          r2_r <= r1_r;
          p2_r <= fcrle_pkg::lead_pos(r1_r.m);
          ctx_q[gi+1] <= c3_nxt;
        end
      end
    end else begin : g_special
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_q[gi+1] <= 1'b0;
        end else if (en) begin
          vld_q[gi+1] <= vld_q[gi];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ctx_q[gi+1] <= fcrle_pkg::step_special(OP.kind, ctx_q[gi]);
        end
      end
    end
  end

  assign out_valid       = vld_q[NOPS];
  assign out_result_bits = ctx_q[NOPS].t;

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow the output stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      $stable(vld_q[NOPS/2]) && (!vld_q[NOPS/2] || $stable(ctx_q[NOPS/2])))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
